>>> rtl/text_glyph_renderer_macros.svh
// Assertion macros used by the checker of the glyph renderer.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef TEXT_GLYPH_RENDERER_MACROS_SVH
`define TEXT_GLYPH_RENDERER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("text_glyph_renderer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("text_glyph_renderer: next-cycle check failed");

`endif

>>> rtl/tgr_pkg.sv
// Types and constants shared by the glyph renderer modules.
// No dependencies.
package tgr_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_WRITE_FONT = 2'd0;
    localparam logic [1:0] OP_SET_CURSOR = 2'd1;
    localparam logic [1:0] OP_DRAW       = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_ONLY  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INK_COLOR    = 2'd3;

    // Register reset values
    localparam logic [4:0] RST_GLYPH_WIDTH  = 5'd8;
    localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd16;

    // Cell size limits
    localparam logic [4:0] GLYPH_W_MAX = 5'd16;
    localparam logic [5:0] GLYPH_H_MAX = 6'd32;

    // Character codes
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Width of the font address field; span of values the address reducer accepts
    localparam int FONT_ADDR_W = 13;
    localparam int RED_SPAN    = 2 ** FONT_ADDR_W;

    typedef struct packed {
        logic [1:0]  operation;
        logic [12:0] font_address;
        logic [7:0]  font_byte;
        logic [6:0]  cursor_x;
        logic [5:0]  cursor_y;
        logic [7:0]  character;
    } in_item_t;

    typedef struct packed {
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic [7:0] pixel_bits;
        logic [3:0] pixel_count;
        logic       last_of_glyph;
    } out_item_t;

    typedef struct packed {
        logic [4:0] glyph_width;
        logic [5:0] glyph_height;
        logic       digits_only_font;
        logic       ink_color;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture the incoming transaction
        logic dispatch;    // register the glyph byte total
        logic set_cursor;  // load the cursor from the transaction
        logic wrap;        // wrap the cursor, start the glyph base reduction
        logic load_red;    // start reduction of the font write address
        logic red_step;    // one conditional subtract of the reducer
        logic mem_write;   // write the font byte
        logic load_addr;   // load the read address, clear run counters
        logic emit;        // load one run into the result register
    } tgr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] operation;
        logic       printable;
        logic       draw;
        logic       red_last;
        logic       out_free;
        logic       run_last;
    } tgr_sts_t;

endpackage

>>> rtl/tgr_ctrl.sv
// Sequencing state machine of the glyph renderer.
// Depends on tgr_pkg for the command and status structs and op codes.
module tgr_ctrl
    import tgr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  tgr_sts_t sts,
    output tgr_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_WRAP     = 3'd2;
    localparam logic [2:0] S_REDUCE   = 3'd3;
    localparam logic [2:0] S_WRITE    = 3'd4;
    localparam logic [2:0] S_PRIME    = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                unique case (sts.operation)
                    OP_WRITE_FONT:
                    begin
                        cmd.load_red = 1'b1;
                        state_next   = S_REDUCE;
                    end
                    OP_SET_CURSOR:
                    begin
                        cmd.set_cursor = 1'b1;
                        state_next     = S_IDLE;
                    end
                    OP_DRAW:
                    begin
                        state_next = sts.printable ? S_WRAP : S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = sts.draw ? S_REDUCE : S_IDLE;
            end
            S_REDUCE:
            begin
                cmd.red_step = 1'b1;
                if (sts.red_last)
                begin
                    state_next = (sts.operation == OP_WRITE_FONT) ? S_WRITE : S_PRIME;
                end
            end
            S_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_PRIME:
            begin
                cmd.load_addr = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.run_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/tgr_dpath.sv
// Datapath of the glyph renderer: cursor, address reducer, font memory, result register.
// Depends on tgr_pkg for the payload, configuration, command and status types.
module tgr_dpath
    import tgr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int FONT_BYTES    = 8192
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  item,
    input  tgr_cmd_t  cmd,
    output tgr_sts_t  sts,
    input  logic      result_ready,
    output logic      result_valid,
    output out_item_t result
);

    localparam int FAW       = $clog2(FONT_BYTES);
    localparam int RDW       = (FAW > FONT_ADDR_W) ? FAW : FONT_ADDR_W;
    localparam int RED_STEPS = $clog2((RED_SPAN + FONT_BYTES - 1) / FONT_BYTES);
    localparam int MOD_SHIFT = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
    localparam int MW        = $clog2(FONT_BYTES + RED_SPAN);
    localparam int XW        = $clog2(SCREEN_WIDTH + 144);
    localparam int YW        = $clog2(SCREEN_HEIGHT + 97);

    localparam logic [MW-1:0]  MOD_INIT  = MW'(FONT_BYTES * (2 ** MOD_SHIFT));
    localparam logic [MW-1:0]  MOD_BASE  = MW'(FONT_BYTES);
    localparam logic [FAW-1:0] ADDR_LAST = FAW'(FONT_BYTES - 1);
    localparam logic [XW-1:0]  X_LIMIT   = XW'(SCREEN_WIDTH);
    localparam logic [YW-1:0]  Y_LIMIT   = YW'(SCREEN_HEIGHT);

    logic [7:0] font_mem [FONT_BYTES];

    in_item_t  item_reg;
    logic [6:0] total_reg, total_next;
    logic [RDW-1:0] red_reg, red_next;
    logic [MW-1:0]  mod_reg, mod_next;
    logic [FAW-1:0] addr_reg, addr_next;
    logic [3:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic [XW-1:0] text_x_reg, text_x_next;
    logic [YW-1:0] text_y_reg, text_y_next;
    logic [7:0] rdata_reg;
    out_item_t result_reg, result_next;
    logic result_valid_reg, result_valid_next;

    logic [4:0] w;
    logic [5:0] h;
    logic [2:0] per_col;
    logic [6:0] code;
    logic       printable;
    logic       draw;
    logic       row_last;
    logic       run_last;
    logic       out_free;
    logic [FAW-1:0] red_addr;
    logic [FAW-1:0] addr_inc;
    logic [FAW-1:0] rd_addr;
    logic [XW-1:0] wx, wrap_x1, wrap_x;
    logic [YW-1:0] hy, wrap_y1, wrap_y;
    logic x_over, y_over;
    logic [5:0] rem;
    logic [3:0] cnt;
    logic [7:0] keep;
    logic [7:0] ink_bits;

    // Clamp the cell size to its legal range
    always_comb
    begin
        if (cfg.glyph_width == 5'd0)
            w = 5'd1;
        else if (cfg.glyph_width > GLYPH_W_MAX)
            w = GLYPH_W_MAX;
        else
            w = cfg.glyph_width;
        if (cfg.glyph_height == 6'd0)
            h = 6'd1;
        else if (cfg.glyph_height > GLYPH_H_MAX)
            h = GLYPH_H_MAX;
        else
            h = cfg.glyph_height;
    end

    assign per_col   = 3'((h + 6'd7) >> 3);
    assign printable = (item_reg.character >= CHAR_FIRST) && (item_reg.character <= CHAR_LAST);
    assign draw      = !cfg.digits_only_font ||
                       ((item_reg.character >= CHAR_ZERO) && (item_reg.character <= CHAR_NINE));
    assign code      = cfg.digits_only_font ? 7'(item_reg.character - CHAR_ZERO)
                                            : 7'(item_reg.character - CHAR_FIRST);

    // Cursor wrap: right edge first, then bottom edge
    assign wx      = XW'(w);
    assign hy      = YW'(h);
    assign x_over  = (text_x_reg + wx) > X_LIMIT;
    assign wrap_x1 = x_over ? '0 : text_x_reg;
    assign wrap_y1 = x_over ? (text_y_reg + hy) : text_y_reg;
    assign y_over  = (wrap_y1 + hy) > Y_LIMIT;
    assign wrap_x  = y_over ? '0 : wrap_x1;
    assign wrap_y  = y_over ? '0 : wrap_y1;

    assign row_last = (row_reg == 2'(per_col - 3'd1));
    assign run_last = row_last && (col_reg == 4'(w - 5'd1));
    assign out_free = !result_valid_reg || result_ready;

    assign red_addr = red_reg[FAW-1:0];
    assign addr_inc = (addr_reg == ADDR_LAST) ? '0 : addr_reg + 1'b1;
    assign rd_addr  = cmd.load_addr ? red_addr : (cmd.emit ? addr_inc : addr_reg);

    // Trim the run to the cell height and apply ink
    assign rem      = h - {1'b0, row_reg, 3'b000};
    assign cnt      = (rem >= 6'd8) ? 4'd8 : rem[3:0];
    assign keep     = 8'(16'hFF00 >> cnt);
    assign ink_bits = (cfg.ink_color ? rdata_reg : ~rdata_reg) & keep;

    always_comb
    begin
        total_next        = total_reg;
        red_next          = red_reg;
        mod_next          = mod_reg;
        addr_next         = addr_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        text_x_next       = text_x_reg;
        text_y_next       = text_y_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        if (cmd.dispatch)
            total_next = 7'({4'b0, per_col} * {2'b0, w});

        if (cmd.load_red)
        begin
            red_next = RDW'(item_reg.font_address);
            mod_next = MOD_INIT;
        end

        if (cmd.wrap)
        begin
            red_next    = RDW'({6'b0, code} * {6'b0, total_reg});
            mod_next    = MOD_INIT;
            text_y_next = wrap_y;
            text_x_next = draw ? wrap_x : wrap_x + wx;
        end

        if (cmd.red_step)
        begin
            if (MW'(red_reg) >= mod_reg)
                red_next = RDW'(MW'(red_reg) - mod_reg);
            mod_next = mod_reg >> 1;
        end

        if (cmd.set_cursor)
        begin
            text_x_next = XW'(item_reg.cursor_x);
            text_y_next = YW'(item_reg.cursor_y);
        end

        if (cmd.load_addr)
        begin
            addr_next = red_addr;
            col_next  = '0;
            row_next  = '0;
        end

        if (cmd.emit)
        begin
            result_next.pixel_x       = 7'(text_x_reg + XW'(col_reg));
            result_next.pixel_y       = 6'(text_y_reg + YW'({row_reg, 3'b000}));
            result_next.pixel_bits    = ink_bits;
            result_next.pixel_count   = cnt;
            result_next.last_of_glyph = run_last;
            result_valid_next         = 1'b1;
            addr_next                 = addr_inc;
            if (row_last)
            begin
                row_next = '0;
                col_next = col_reg + 4'd1;
            end
            else
            begin
                row_next = row_reg + 2'd1;
            end
            if (run_last)
                text_x_next = text_x_reg + wx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_x_reg       <= '0;
            text_y_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            text_x_reg       <= text_x_next;
            text_y_reg       <= text_y_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= item;
        total_reg  <= total_next;
        red_reg    <= red_next;
        mod_reg    <= mod_next;
        addr_reg   <= addr_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        result_reg <= result_next;
    end

    // Font memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            font_mem[red_addr] <= item_reg.font_byte;
        rdata_reg <= font_mem[rd_addr];
    end

    assign sts.operation = item_reg.operation;
    assign sts.printable = printable;
    assign sts.draw      = draw;
    assign sts.red_last  = (mod_reg == MOD_BASE);
    assign sts.out_free  = out_free;
    assign sts.run_last  = run_last;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/text_glyph_renderer.sv
// Top level of the bitmap font character generator: configuration registers,
// controller and datapath. Depends on tgr_pkg, tgr_ctrl and tgr_dpath.
//
// Usage:
//   item channel (item_valid/item_ready/item): one transaction writes a font byte,
//   sets the text cursor or draws one character at the cursor.
//   result channel (result_valid/result_ready/result): one transaction per
//   vertical pixel run of up to 8 pixels; last_of_glyph marks a character's end.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write the
//   cell width, height, digits-only flag and ink colour only while the block is idle.
// Timing: an item is taken only when the controller is idle, and the controller
//   handles one item at a time. A draw gives one run per cycle while the result
//   register is free, set by the single read port of the font memory and the
//   run-by-run sequencer. The font address unit makes 1 reduction step at the
//   default store size.
// Reset: cursor at the origin, registers to 8x16 cells, full font, ink 1; the font
//   store is not cleared and must be written before use.
// Stall: a run waits in the result register while result_ready is low; the
//   sequencer holds until the register frees, and a new item may be taken
//   once the last run is loaded even if it has not yet been taken.
module text_glyph_renderer
    import tgr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int FONT_BYTES    = 8192
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  in_item_t               item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    tgr_cmd_t cmd;
    tgr_sts_t sts;

    // Configuration writes are taken every cycle
    assign cfg_ready = 1'b1;

    // Decode the register index and update the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GLYPH_WIDTH:  cfg_next.glyph_width      = cfg_data[4:0];
                CFG_GLYPH_HEIGHT: cfg_next.glyph_height     = cfg_data[5:0];
                CFG_DIGITS_ONLY:  cfg_next.digits_only_font = cfg_data[0];
                CFG_INK_COLOR:    cfg_next.ink_color        = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width      <= RST_GLYPH_WIDTH;
            cfg_reg.glyph_height     <= RST_GLYPH_HEIGHT;
            cfg_reg.digits_only_font <= 1'b0;
            cfg_reg.ink_color        <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: one item at a time
    tgr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Cursor, address reduction, font memory and result register
    tgr_dpath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FONT_BYTES    (FONT_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> rtl/tgr_checker.sv
// Port-level checks of the glyph renderer's result channel, bound to the top level.
// Depends on tgr_pkg and text_glyph_renderer_macros.svh.
`include "text_glyph_renderer_macros.svh"

module tgr_checker
    import tgr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result
);

    // Hold a stalled run
    `TGR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
    `TGR_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result))

    // A run carries between one and eight pixels
    `TGR_ASSERT_NOW(a_count_range, result_valid, (result.pixel_count != 4'd0) && (result.pixel_count <= 4'd8))

    // Pixels below the run's count read as zero
    `TGR_ASSERT_NOW(a_trim_zero, result_valid, (result.pixel_bits & 8'(16'h00FF >> result.pixel_count)) == 8'd0)

endmodule

bind text_glyph_renderer tgr_checker u_tgr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
